// File: rtl/rlow_pkg.sv
// ----------------------------------------------------------------------------
// rlow_pkg: shared definitions for the one-wire RGB LED line encoder
// Widths, register indexes, reset values, command and phase types, and the
// segment length and bit select helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rlow_pkg;

  // Frame geometry
  localparam int BITS_PER_PIXEL = 24;
  localparam int COLOR_W        = 24;
  localparam int POS_W          = 5;

  // Field widths
  localparam int TICK_W     = 16;
  localparam int SEG_W      = 8;
  localparam int REP_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd5;

  // Register reset values
  localparam logic [SEG_W-1:0]  RST_ZERO_HIGH = 8'd8;
  localparam logic [SEG_W-1:0]  RST_ZERO_LOW  = 8'd17;
  localparam logic [SEG_W-1:0]  RST_ONE_HIGH  = 8'd16;
  localparam logic [SEG_W-1:0]  RST_ONE_LOW   = 8'd9;
  localparam logic [TICK_W-1:0] RST_GAP       = 16'd1000;
  localparam logic [REP_W-1:0]  RST_REPEAT    = 4'd10;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COLOR_W-1:0] grb;
  } cmd_t;

  // Front to queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  // Queue head seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    CTL_RUN  = 2'b01,
    CTL_SEEK = 2'b10
  } ctl_t;

  typedef struct packed {
    logic [SEG_W-1:0]  zero_high_ticks;
    logic [SEG_W-1:0]  zero_low_ticks;
    logic [SEG_W-1:0]  one_high_ticks;
    logic [SEG_W-1:0]  one_low_ticks;
    logic [TICK_W-1:0] gap_ticks;
    logic [REP_W-1:0]  repeat_count;
  } cfg_regs_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic load_accepted;
  } res_t;

  // Bit of the frame word at a position; positions past the color are zero
  function automatic logic bit_at(logic [COLOR_W-1:0] color, logic [POS_W-1:0] pos);
    logic b;
    b = 1'b0;
    if (pos < POS_W'(COLOR_W)) begin
      b = color[POS_W'(COLOR_W - 1) - pos];
    end
    return b;
  endfunction

  // Tick length of a segment
  function automatic logic [TICK_W-1:0] seg_len(phase_t ph, logic b, cfg_regs_t c);
    logic [TICK_W-1:0] len;
    len = '0;
    case (ph)
      PH_GAP:  len = c.gap_ticks;
      PH_HIGH: len = b ? TICK_W'(c.one_high_ticks) : TICK_W'(c.zero_high_ticks);
      PH_LOW:  len = b ? TICK_W'(c.one_low_ticks) : TICK_W'(c.zero_low_ticks);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rlow_ifs.sv
// ----------------------------------------------------------------------------
// rlow_ifs: channel interfaces of the LED line encoder
// Item input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlow_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, red, green, blue, input ready);
  modport sink   (input valid, func, red, green, blue, output ready);
endinterface

interface rlow_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic frame_done;
  logic load_accepted;

  modport source (output valid, pin_level, busy_res, frame_done, load_accepted,
                  input ready);
  modport sink   (input valid, pin_level, busy_res, frame_done, load_accepted,
                  output ready);
endinterface

interface rlow_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rlow_pkg::CFG_IDX_W-1:0]     index;
  logic [rlow_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/rlow_front.sv
// ----------------------------------------------------------------------------
// rlow_front: item intake
// Accepts items while the queue has room, classifies them into load or tick
// commands and packs the color in line order (green, red, blue).
// ----------------------------------------------------------------------------
`default_nettype none

module rlow_front (
  rlow_in_if.sink            item,
  input  logic               full,
  output rlow_pkg::q_push_t  push
);

  // Take a beat whenever the queue can hold it
  assign item.ready = !full;

  // Classify and pack
  always_comb begin
    push.valid    = item.valid && !full;
    push.cmd.kind = item.func ? rlow_pkg::CMD_TICK : rlow_pkg::CMD_LOAD;
    push.cmd.grb  = {item.green, item.red, item.blue};
  end

endmodule

`default_nettype wire

// File: rtl/rlow_queue.sv
// ----------------------------------------------------------------------------
// rlow_queue: command queue
// Small FIFO between intake and line sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module rlow_queue (
  input  logic               clk,
  input  logic               rst,
  input  rlow_pkg::q_push_t  push,
  output logic               full,
  output rlow_pkg::q_head_t  head,
  input  logic               pop
);

  rlow_pkg::cmd_t                 mem [rlow_pkg::QUEUE_DEPTH];
  logic [rlow_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rlow_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rlow_pkg::QPTR_W:0]      count;
  logic                           do_pop;

  assign full       = (count == (rlow_pkg::QPTR_W + 1)'(rlow_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + rlow_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rlow_pkg::QPTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        count <= count + (rlow_pkg::QPTR_W + 1)'(1);
      end else if (!push.valid && do_pop) begin
        count <= count - (rlow_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rlow_back.sv
// ----------------------------------------------------------------------------
// rlow_back: line sequencer
// Holds the timing registers and frame state, executes one command per
// cycle while the result register is free and no seek is under way, and walks
// past zero-length segments one per cycle, while the result register is free,
// before a result that ends a segment is released.
`default_nettype none

module rlow_back (
  input  logic               clk,
  input  logic               rst,
  input  rlow_pkg::q_head_t  head,
  output logic               pop,
  rlow_cfg_if.sink           cfg,
  rlow_out_if.source         result
);

  rlow_pkg::cfg_regs_t                 cfg_regs;
  rlow_pkg::ctl_t                      ctl, ctl_next;
  rlow_pkg::phase_t                    phase, phase_next;
  logic [rlow_pkg::COLOR_W-1:0]        color, color_next;
  logic [rlow_pkg::POS_W-1:0]          bit_pos, bit_pos_next;
  logic [rlow_pkg::TICK_W-1:0]         ticks_left, ticks_left_next;
  logic [rlow_pkg::REP_W-1:0]          repeats_left, repeats_left_next;
  logic                                active, active_next;
  logic                                any_nz, any_nz_next;
  logic                                pend_pin, pend_pin_next;
  logic                                pend_load, pend_load_next;
  logic                                res_valid;
  rlow_pkg::res_t                      res;

  logic                                out_free;
  logic                                emit;
  rlow_pkg::res_t                      emit_res;
  logic [rlow_pkg::TICK_W-1:0]         load_len;
  logic [rlow_pkg::TICK_W-1:0]         tick_dec;
  logic                                tick_pin;

  rlow_pkg::phase_t                    adv_phase;
  logic [rlow_pkg::POS_W-1:0]          adv_pos;
  logic [rlow_pkg::REP_W-1:0]          adv_rep;
  logic                                adv_wrap;
  logic                                adv_stop;
  logic                                adv_end;
  logic [rlow_pkg::TICK_W-1:0]         adv_len;
  logic [rlow_pkg::POS_W:0]            pos_inc;

  // Configuration registers; lengths are sampled as each segment starts
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.zero_high_ticks <= rlow_pkg::RST_ZERO_HIGH;
      cfg_regs.zero_low_ticks  <= rlow_pkg::RST_ZERO_LOW;
      cfg_regs.one_high_ticks  <= rlow_pkg::RST_ONE_HIGH;
      cfg_regs.one_low_ticks   <= rlow_pkg::RST_ONE_LOW;
      cfg_regs.gap_ticks       <= rlow_pkg::RST_GAP;
      cfg_regs.repeat_count    <= rlow_pkg::RST_REPEAT;
    end else if (cfg.valid) begin
      case (cfg.index)
        rlow_pkg::REG_ZERO_HIGH: cfg_regs.zero_high_ticks <= cfg.data[rlow_pkg::SEG_W-1:0];
        rlow_pkg::REG_ZERO_LOW:  cfg_regs.zero_low_ticks  <= cfg.data[rlow_pkg::SEG_W-1:0];
        rlow_pkg::REG_ONE_HIGH:  cfg_regs.one_high_ticks  <= cfg.data[rlow_pkg::SEG_W-1:0];
        rlow_pkg::REG_ONE_LOW:   cfg_regs.one_low_ticks   <= cfg.data[rlow_pkg::SEG_W-1:0];
        rlow_pkg::REG_GAP:       cfg_regs.gap_ticks       <= cfg.data[rlow_pkg::TICK_W-1:0];
        rlow_pkg::REG_REPEAT:    cfg_regs.repeat_count    <= cfg.data[rlow_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  // One step to the following segment of the frame
  always_comb begin
    adv_phase = phase;
    adv_pos   = bit_pos;
    adv_rep   = repeats_left;
    adv_wrap  = 1'b0;
    adv_stop  = 1'b0;
    pos_inc   = {1'b0, bit_pos} + (rlow_pkg::POS_W + 1)'(1);
    case (phase)
      rlow_pkg::PH_HIGH: begin
        adv_phase = rlow_pkg::PH_LOW;
      end
      rlow_pkg::PH_LOW: begin
        if (pos_inc >= (rlow_pkg::POS_W + 1)'(rlow_pkg::BITS_PER_PIXEL)) begin
          adv_phase = rlow_pkg::PH_GAP;
        end else begin
          adv_pos   = pos_inc[rlow_pkg::POS_W-1:0];
          adv_phase = rlow_pkg::PH_HIGH;
        end
      end
      rlow_pkg::PH_GAP: begin
        if (repeats_left > rlow_pkg::REP_W'(1)) begin
          adv_rep   = repeats_left - rlow_pkg::REP_W'(1);
          adv_pos   = '0;
          adv_phase = rlow_pkg::PH_HIGH;
          adv_wrap  = 1'b1;
        end else begin
          adv_stop = 1'b1;
        end
      end
      default: adv_stop = 1'b1;
    endcase
    // A full pass with no nonzero segment means every repeat is empty
    adv_end = adv_stop || (adv_wrap && !any_nz);
    adv_len = rlow_pkg::seg_len(adv_phase, rlow_pkg::bit_at(color, adv_pos), cfg_regs);
  end

  assign out_free = !res_valid || result.ready;
  assign load_len = rlow_pkg::seg_len(rlow_pkg::PH_HIGH,
                                      head.cmd.grb[rlow_pkg::COLOR_W-1], cfg_regs);
  assign tick_dec = ticks_left - rlow_pkg::TICK_W'(1);
  assign tick_pin = (phase == rlow_pkg::PH_HIGH);

  // Command execution and segment walk
  always_comb begin
    ctl_next          = ctl;
    phase_next        = phase;
    color_next        = color;
    bit_pos_next      = bit_pos;
    ticks_left_next   = ticks_left;
    repeats_left_next = repeats_left;
    active_next       = active;
    any_nz_next       = any_nz;
    pend_pin_next     = pend_pin;
    pend_load_next    = pend_load;
    pop               = 1'b0;
    emit              = 1'b0;
    emit_res          = '0;
    case (ctl)
      rlow_pkg::CTL_RUN: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          if (head.cmd.kind == rlow_pkg::CMD_LOAD) begin
            if (active) begin
              // Refuse a load while the frame is running
              emit              = 1'b1;
              emit_res.busy_res = 1'b1;
            end else begin
              color_next        = head.cmd.grb;
              repeats_left_next = (cfg_regs.repeat_count == '0) ?
                                  rlow_pkg::REP_W'(1) : cfg_regs.repeat_count;
              bit_pos_next      = '0;
              phase_next        = rlow_pkg::PH_HIGH;
              active_next       = 1'b1;
              ticks_left_next   = load_len;
              if (load_len != '0) begin
                emit                   = 1'b1;
                emit_res.busy_res      = 1'b1;
                emit_res.load_accepted = 1'b1;
              end else begin
                ctl_next       = rlow_pkg::CTL_SEEK;
                pend_pin_next  = 1'b0;
                pend_load_next = 1'b1;
                any_nz_next    = 1'b0;
              end
            end
          end else if (active) begin
            ticks_left_next = tick_dec;
            if (tick_dec != '0) begin
              emit               = 1'b1;
              emit_res.pin_level = tick_pin;
              emit_res.busy_res  = 1'b1;
            end else begin
              ctl_next       = rlow_pkg::CTL_SEEK;
              pend_pin_next  = tick_pin;
              pend_load_next = 1'b0;
              any_nz_next    = 1'b1;
            end
          end else begin
            // Idle tick: line low
            emit = 1'b1;
          end
        end
      end
      rlow_pkg::CTL_SEEK: begin
        if (out_free) begin
          if (adv_end) begin
            // Frame over: drop back to idle
            active_next            = 1'b0;
            phase_next             = rlow_pkg::PH_IDLE;
            ticks_left_next        = '0;
            repeats_left_next      = '0;
            bit_pos_next           = '0;
            ctl_next               = rlow_pkg::CTL_RUN;
            emit                   = 1'b1;
            emit_res.pin_level     = pend_pin;
            emit_res.frame_done    = !pend_load;
            emit_res.load_accepted = pend_load;
          end else begin
            phase_next        = adv_phase;
            bit_pos_next      = adv_pos;
            repeats_left_next = adv_rep;
            ticks_left_next   = adv_len;
            if (adv_len != '0) begin
              ctl_next               = rlow_pkg::CTL_RUN;
              emit                   = 1'b1;
              emit_res.pin_level     = pend_pin;
              emit_res.busy_res      = 1'b1;
              emit_res.load_accepted = pend_load;
            end
          end
        end
      end
      default: ctl_next = rlow_pkg::CTL_RUN;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= rlow_pkg::CTL_RUN;
      phase        <= rlow_pkg::PH_IDLE;
      bit_pos      <= '0;
      ticks_left   <= '0;
      repeats_left <= '0;
      active       <= 1'b0;
      any_nz       <= 1'b0;
      pend_pin     <= 1'b0;
      pend_load    <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      ctl          <= ctl_next;
      phase        <= phase_next;
      bit_pos      <= bit_pos_next;
      ticks_left   <= ticks_left_next;
      repeats_left <= repeats_left_next;
      active       <= active_next;
      any_nz       <= any_nz_next;
      pend_pin     <= pend_pin_next;
      pend_load    <= pend_load_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Color word and result payload
  always_ff @(posedge clk) begin
    color <= color_next;
    if (emit) begin
      res <= emit_res;
    end
  end

  assign result.valid         = res_valid;
  assign result.pin_level     = res.pin_level;
  assign result.busy_res      = res.busy_res;
  assign result.frame_done    = res.frame_done;
  assign result.load_accepted = res.load_accepted;

endmodule

`default_nettype wire

// File: rtl/rgb_led_one_wire_encoder.sv
// Path: an accepted item is written into the command queue, executed by the
//   sequencer and its result registered; a segment end first takes a seek
//   step per segment passed over (up to 49 after a load, up to 735 after a
//   tick once the lengths are cleared mid-frame); items wait meanwhile.
// Reset (synchronous, active high): line idle, command queue empty, result
//   register empty, timing registers at their defaults.
// ----------------------------------------------------------------------------
// rgb_led_one_wire_encoder: one-wire RGB LED line encoder
// Intake and classification, a command queue, and a line sequencer that
// shapes each color bit into high and low segments with a gap after each repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_one_wire_encoder (
  input  logic        clk,
  input  logic        rst,
  rlow_in_if.sink     item,
  rlow_cfg_if.sink    cfg,
  rlow_out_if.source  result
);

  rlow_pkg::q_push_t  push;
  rlow_pkg::q_head_t  head;
  logic               full;
  logic               pop;

  // Classify incoming beats
  rlow_front u_front (
    .item (item),
    .full (full),
    .push (push)
  );

  // Hold commands between intake and sequencer
  rlow_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  // Drive the line timing
  rlow_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .cfg    (cfg),
    .result (result)
  );

endmodule

`default_nettype wire

// File: dv/rgb_led_one_wire_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_one_wire_encoder_test: self-checking bench for the LED line encoder
// Drives load and tick beats with random gaps, stalls the result side at
// random, and checks every result beat against a cycle-free model of the
// bit, gap and repeat sequencing. Timing registers are rewritten between
// phases, from the reset values through zero lengths and the maxima to small random settings.
// ----------------------------------------------------------------------------

module rgb_led_one_wire_encoder_test;
  import rlow_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SEEK_GUARD  = (2 * 32 + 1) * 16 + 2;
  localparam int DRAIN_WAIT  = 60;
  localparam int PHASE_ITEMS = 120;

  // No register lives at this index; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    cmd_kind_t  func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rlow_in_if  item_ch ();
  rlow_cfg_if cfg_ch ();
  rlow_out_if res_ch ();

  rgb_led_one_wire_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  always #5 clk = ~clk;

  // Stimulus and expected results
  led_item_t items_q[$];
  res_t      line_exp_q[$];
  int        queued       = 0;
  int        errors       = 0;
  int        quiet_cycles = 0;
  logic      idle_on      = 1'b1;
  logic      in_taken     = 1'b0;
  int        send_gap     = 0;
  int        hold_left    = 0;
  led_item_t drv_item;
  led_item_t mon_item;
  res_t      mon_got;
  res_t      mon_exp;

  // Timing the stimulus generator assumes, and the model's own copy
  cfg_regs_t gen_cfg;
  cfg_regs_t mdl_cfg;

  // Line sequencer model
  logic [COLOR_W-1:0] mdl_color;
  logic [POS_W-1:0]   mdl_pos;
  phase_t             mdl_phase;
  logic [TICK_W-1:0]  mdl_ticks;
  logic [REP_W-1:0]   mdl_reps;
  logic               mdl_active;

  // Length of the segment the model now stands in
  function automatic logic [TICK_W-1:0] seg_ticks();
    logic b;
    b = mdl_color[BITS_PER_PIXEL - 1 - int'(mdl_pos)];
    case (mdl_phase)
      PH_GAP:  return mdl_cfg.gap_ticks;
      PH_HIGH: return b ? TICK_W'(mdl_cfg.one_high_ticks) : TICK_W'(mdl_cfg.zero_high_ticks);
      PH_LOW:  return b ? TICK_W'(mdl_cfg.one_low_ticks) : TICK_W'(mdl_cfg.zero_low_ticks);
      default: return '0;
    endcase
  endfunction

  // Step past zero-length segments; return 1 once the final repeat is over
  function automatic logic seek_segment();
    for (int n = 0; n < SEEK_GUARD; n++) begin
      if (mdl_phase == PH_HIGH) begin
        mdl_phase = PH_LOW;
      end else if (mdl_phase == PH_LOW) begin
        if (int'(mdl_pos) + 1 >= BITS_PER_PIXEL) begin
          mdl_phase = PH_GAP;
        end else begin
          mdl_pos   = mdl_pos + 5'd1;
          mdl_phase = PH_HIGH;
        end
      end else if (mdl_reps > 4'd1) begin
        mdl_reps  = mdl_reps - 4'd1;
        mdl_pos   = '0;
        mdl_phase = PH_HIGH;
      end else begin
        break;
      end
      mdl_ticks = seg_ticks();
      if (mdl_ticks != '0) return 1'b0;
    end
    mdl_active = 1'b0;
    mdl_phase  = PH_IDLE;
    mdl_ticks  = '0;
    mdl_reps   = '0;
    mdl_pos    = '0;
    return 1'b1;
  endfunction

  // Advance the model by one beat and return the result it causes
  function automatic res_t line_step(led_item_t it);
    res_t r;
    r = '0;
    if (it.func == CMD_LOAD) begin
      if (!mdl_active) begin
        mdl_color  = {it.green, it.red, it.blue};
        mdl_reps   = (mdl_cfg.repeat_count == '0) ? 4'd1 : mdl_cfg.repeat_count;
        mdl_pos    = '0;
        mdl_phase  = PH_HIGH;
        mdl_active = 1'b1;
        mdl_ticks  = seg_ticks();
        if (mdl_ticks == '0) void'(seek_segment());
        r.load_accepted = 1'b1;
      end
    end else if (mdl_active) begin
      r.pin_level = (mdl_phase == PH_HIGH);
      mdl_ticks   = mdl_ticks - 16'd1;
      if (mdl_ticks == '0 && seek_segment()) r.frame_done = 1'b1;
    end
    r.busy_res = mdl_active;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (!idle_on || r < 60) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // Ticks one load keeps the line busy under the generator's timing
  function automatic int frame_ticks(logic [COLOR_W-1:0] grb);
    int ones;
    int per_rep;
    ones    = $countones(grb);
    per_rep = ones * (int'(gen_cfg.one_high_ticks) + int'(gen_cfg.one_low_ticks))
            + (BITS_PER_PIXEL - ones)
              * (int'(gen_cfg.zero_high_ticks) + int'(gen_cfg.zero_low_ticks))
            + int'(gen_cfg.gap_ticks);
    return per_rep * ((gen_cfg.repeat_count == '0) ? 1 : int'(gen_cfg.repeat_count));
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic push_item(cmd_kind_t f, logic [COLOR_W-1:0] grb);
    led_item_t it;
    it.func  = f;
    it.green = grb[23:16];
    it.red   = grb[15:8];
    it.blue  = grb[7:0];
    items_q.push_back(it);
    queued++;
  endtask

  // Tick beats carry random color fields, which the block must ignore
  task automatic push_ticks(int n);
    repeat (n) push_item(CMD_TICK, 24'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  // Write all six registers; unused upper data bits get random junk
  task automatic apply_cfg(cfg_regs_t c);
    gen_cfg = c;
    write_reg(REG_ZERO_HIGH, {8'($urandom), c.zero_high_ticks});
    write_reg(REG_ZERO_LOW,  {8'($urandom), c.zero_low_ticks});
    write_reg(REG_ONE_HIGH,  {8'($urandom), c.one_high_ticks});
    write_reg(REG_ONE_LOW,   {8'($urandom), c.one_low_ticks});
    write_reg(REG_GAP,       c.gap_ticks);
    write_reg(REG_REPEAT,    {12'($urandom), c.repeat_count});
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every queued beat is sent and every result has come back;
  // sample at the rising edge, where the driver does not move
  task automatic wait_idle();
    do @(posedge clk);
    while (items_q.size() != 0 || item_ch.valid || line_exp_q.size() != 0);
  endtask

  // Driver: present the next beat once the current one is taken
  always @(negedge clk) begin
    if (!rst && (!item_ch.valid || in_taken)) begin
      if (send_gap != 0) begin
        item_ch.valid <= 1'b0;
        send_gap--;
      end else if (items_q.size() != 0) begin
        drv_item = items_q.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.func  <= drv_item.func;
        item_ch.red   <= drv_item.red;
        item_ch.green <= drv_item.green;
        item_ch.blue  <= drv_item.blue;
        send_gap = pick_gap();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  // Monitor: track register writes, check results, predict accepted beats
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken <= item_ch.valid && item_ch.ready;

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_ZERO_HIGH: mdl_cfg.zero_high_ticks = cfg_ch.data[SEG_W-1:0];
          REG_ZERO_LOW:  mdl_cfg.zero_low_ticks  = cfg_ch.data[SEG_W-1:0];
          REG_ONE_HIGH:  mdl_cfg.one_high_ticks  = cfg_ch.data[SEG_W-1:0];
          REG_ONE_LOW:   mdl_cfg.one_low_ticks   = cfg_ch.data[SEG_W-1:0];
          REG_GAP:       mdl_cfg.gap_ticks       = cfg_ch.data[TICK_W-1:0];
          REG_REPEAT:    mdl_cfg.repeat_count    = cfg_ch.data[REP_W-1:0];
          default: ;
        endcase
      end

      if (res_ch.valid && res_ch.ready) begin
        mon_got.pin_level     = res_ch.pin_level;
        mon_got.busy_res      = res_ch.busy_res;
        mon_got.frame_done    = res_ch.frame_done;
        mon_got.load_accepted = res_ch.load_accepted;
        if (line_exp_q.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected: pin %b busy %b done %b acc %b",
                               mon_got.pin_level, mon_got.busy_res, mon_got.frame_done,
                               mon_got.load_accepted));
        end else begin
          mon_exp = line_exp_q.pop_front();
          if (mon_got.pin_level !== mon_exp.pin_level ||
              mon_got.busy_res !== mon_exp.busy_res ||
              mon_got.frame_done !== mon_exp.frame_done ||
              mon_got.load_accepted !== mon_exp.load_accepted) begin
            flag_error($sformatf(
              "result mismatch: exp pin %b busy %b done %b acc %b, got pin %b busy %b done %b acc %b",
              mon_exp.pin_level, mon_exp.busy_res, mon_exp.frame_done, mon_exp.load_accepted,
              mon_got.pin_level, mon_got.busy_res, mon_got.frame_done, mon_got.load_accepted));
          end
        end
      end

      if (item_ch.valid && item_ch.ready) begin
        mon_item.func  = cmd_kind_t'(item_ch.func);
        mon_item.red   = item_ch.red;
        mon_item.green = item_ch.green;
        mon_item.blue  = item_ch.blue;
        line_exp_q.push_back(line_step(mon_item));
      end

      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(negedge clk);
    $display("rgb_led_one_wire_encoder_test: errors");
    $finish;
  end

  initial begin
    cfg_regs_t        c;
    logic [COLOR_W-1:0] grb;
    int               r;
    int               start_n;
    int               frame;
    int               budget;
    int               n;

    item_ch.valid = 1'b0;
    item_ch.func  = 1'b0;
    item_ch.red   = '0;
    item_ch.green = '0;
    item_ch.blue  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    res_ch.ready  = 1'b0;

    mdl_cfg = '{zero_high_ticks: RST_ZERO_HIGH, zero_low_ticks: RST_ZERO_LOW,
                one_high_ticks: RST_ONE_HIGH, one_low_ticks: RST_ONE_LOW,
                gap_ticks: RST_GAP, repeat_count: RST_REPEAT};
    gen_cfg    = mdl_cfg;
    mdl_color  = '0;
    mdl_pos    = '0;
    mdl_phase  = PH_IDLE;
    mdl_ticks  = '0;
    mdl_reps   = '0;
    mdl_active = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timing: idle tick, a load, a refused load while busy
    push_item(CMD_TICK, 24'hFFFFFF);
    push_item(CMD_LOAD, 24'h5AC30F);
    push_ticks(4);
    push_item(CMD_LOAD, 24'hFFFFFF);
    push_ticks(1);
    wait_idle();

    // Zero-length bit segments: the running frame drops through to its gaps
    apply_cfg('{8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 4'd1});
    push_ticks(15);
    wait_idle();

    // Repeat count of zero sends once; only the one bits and the gap take line time
    apply_cfg('{8'd0, 8'd0, 8'd1, 8'd0, 16'd1, 4'd0});
    push_item(CMD_LOAD, 24'h800001);
    push_ticks(4);
    wait_idle();

    // Frame of zero total length: load taken, line never busy
    write_reg(REG_NONE, 16'hFFFF);
    apply_cfg('{8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 4'd15});
    push_item(CMD_LOAD, 24'hFFFFFF);
    push_ticks(1);
    push_item(CMD_LOAD, 24'h000000);
    push_ticks(1);
    wait_idle();

    // Every register at its maximum
    apply_cfg('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 4'hF});
    push_item(CMD_LOAD, 24'hFFFFFF);
    push_ticks(3);
    push_item(CMD_LOAD, 24'h000000);
    wait_idle();

    // Shrink the timing so the long frame runs out through its gaps
    apply_cfg('{8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 4'd1});
    push_ticks(280);
    wait_idle();

    // Random phases: mostly complete frames, some cut short, some noise
    for (int p = 0; p < 6; p++) begin
      idle_on = (p % 3) != 1;
      c.zero_high_ticks = 8'($urandom_range(0, 2));
      c.zero_low_ticks  = 8'($urandom_range(0, 2));
      c.one_high_ticks  = 8'($urandom_range(0, 2));
      c.one_low_ticks   = 8'($urandom_range(0, 2));
      c.gap_ticks       = 16'($urandom_range(0, 4));
      c.repeat_count    = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 2));
      apply_cfg(c);
      start_n = queued;
      while (queued - start_n < PHASE_ITEMS) begin
        budget = PHASE_ITEMS - (queued - start_n);
        case ($urandom_range(0, 3))
          0:       grb = 24'($urandom);
          1:       grb = 24'($urandom & $urandom);
          2:       grb = 24'($urandom | $urandom);
          default: grb = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        endcase
        frame = frame_ticks(grb);
        r     = int'($urandom_range(0, 99));
        if (r < 70) begin
          push_item(CMD_LOAD, grb);
          n = frame + int'($urandom_range(0, 2));
          push_ticks((n < budget) ? n : budget);
        end else if (r < 88) begin
          push_item(CMD_LOAD, grb);
          n = int'($urandom_range(0, frame));
          push_ticks((n < budget) ? n : budget);
          push_item(CMD_LOAD, 24'($urandom));
        end else begin
          repeat (int'($urandom_range(1, 4)))
            push_item(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_LOAD, 24'($urandom));
        end
      end
      wait_idle();
    end

    // Let any stray result beats show up before the verdict
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0 && line_exp_q.size() == 0)
      $display("rgb_led_one_wire_encoder_test: clean");
    else
      $display("rgb_led_one_wire_encoder_test: errors");
    $finish;
  end

endmodule
